[src/lskv_pkg.sv]
// shared types and constants for the linear scan key/value table
package lskv_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int OP_W          = 3;
    localparam int KEY_W         = 32;
    localparam int VAL_W         = 32;
    localparam int POS_W         = 6;
    localparam int STATUS_W      = 2;
    localparam int COUNT_OUT_W   = 7;

    typedef enum logic [OP_W-1:0] {
        OP_PUT      = 3'd0,
        OP_GET      = 3'd1,
        OP_HAS      = 3'd2,
        OP_REMOVE   = 3'd3,
        OP_KEY_AT   = 3'd4,
        OP_VALUE_AT = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_VAL,
        S_RM_A,
        S_RM_B,
        S_POS,
        S_POS_D,
        S_DONE
    } state_t;

endpackage

[src/lskv_if.sv]
// request and response channel interfaces of the key/value table
interface lskv_req_if;
    logic                          valid;
    logic                          ready;
    logic [lskv_pkg::OP_W-1:0]     opcode;
    logic [lskv_pkg::KEY_W-1:0]    key;
    logic [lskv_pkg::VAL_W-1:0]    value;
    logic [lskv_pkg::POS_W-1:0]    position;

    modport source (output valid, opcode, key, value, position, input ready);
    modport sink (input valid, opcode, key, value, position, output ready);
endinterface

interface lskv_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             found;
    logic [lskv_pkg::VAL_W-1:0]       result_value;
    logic [lskv_pkg::KEY_W-1:0]       result_key;
    logic [lskv_pkg::STATUS_W-1:0]    status;
    logic [lskv_pkg::COUNT_OUT_W-1:0] entry_count;

    modport source (output valid, found, result_value, result_key, status, entry_count,
                    input ready);
    modport sink (input valid, found, result_value, result_key, status, entry_count,
                  output ready);
endinterface

[src/lskv_ram.sv]
// single write port, single read port synchronous ram with registered read data
module lskv_ram #(
    parameter int AW = 6,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/linear_scan_key_value_table_top.sv]
// top level of the linear scan key/value table
//
// channel | role   | moves
// --------+--------+-----------------------------------------------------------
// req     | sink   | request: opcode, key, value, position
// rsp     | source | result: found, result_value, result_key, status, entry_count
//
// one request at a time. put, get, has-key and remove scan the filled keys at one
// key per cycle through the key ram read port; a get hit then reads the value ram,
// and a remove hit moves the last entry into the freed slot, key first, then value.
// positional reads pass S_POS, then S_POS_D when in range; unused opcodes go to
// S_DONE directly. reset clears the fill count, the control state and the output
// valid; the rams keep their contents and data beyond the fill count is never used.
// the result sits in an output register, so a new request is taken while the
// previous result still waits for rsp.ready; a full output register holds the
// next result back in its final cycle.
module linear_scan_key_value_table_top #(
    parameter int DEPTH = lskv_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    lskv_req_if.sink    req,
    lskv_rsp_if.source  rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > lskv_pkg::POS_W) ? CW : lskv_pkg::POS_W;

    // control state
    lskv_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    issue_reg, issue_next;   // next slot to read in the scan
    logic             rdv_reg, rdv_next;       // key read data is live
    logic [AW-1:0]    rdidx_reg, rdidx_next;   // slot of the live key read data
    logic [AW-1:0]    slot_reg, slot_next;     // slot that matched
    logic             out_valid_reg, out_valid_next;

    // request held for the duration of the operation
    logic [lskv_pkg::OP_W-1:0]  op_reg;
    logic [lskv_pkg::KEY_W-1:0] key_reg;
    logic [lskv_pkg::VAL_W-1:0] val_reg;
    logic [lskv_pkg::POS_W-1:0] pos_reg;

    // result being built, then the output register
    logic                       res_found_reg, res_found_next;
    logic [lskv_pkg::VAL_W-1:0] res_val_reg, res_val_next;
    logic [lskv_pkg::KEY_W-1:0] res_key_reg, res_key_next;
    lskv_pkg::status_t          res_status_reg, res_status_next;

    logic                           out_found_reg;
    logic [lskv_pkg::VAL_W-1:0]     out_val_reg;
    logic [lskv_pkg::KEY_W-1:0]     out_key_reg;
    lskv_pkg::status_t              out_status_reg;
    logic [lskv_pkg::COUNT_OUT_W-1:0] out_count_reg;

    // ram ports
    logic                       key_we, val_we;
    logic [AW-1:0]              key_waddr, val_waddr, key_raddr, val_raddr;
    logic [lskv_pkg::KEY_W-1:0] key_wdata, key_rdata;
    logic [lskv_pkg::VAL_W-1:0] val_wdata, val_rdata;

    logic          req_fire;
    logic          out_load;
    logic          hit;
    logic          scan_end;
    logic          in_range;
    logic [AW-1:0] last_slot;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] count_x;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == lskv_pkg::S_IDLE);
    assign out_load  = (state_reg == lskv_pkg::S_DONE) && (!out_valid_reg || rsp.ready);

    // compare of the key read issued last cycle; the scan ends when every
    // filled slot has been read and the last one did not match
    assign hit       = rdv_reg && (key_rdata == key_reg);
    assign scan_end  = (issue_reg == count_reg) && !hit;
    assign last_slot = AW'(count_reg - CW'(1));
    assign pos_x     = XW'(pos_reg);
    assign count_x   = XW'(count_reg);
    assign in_range  = pos_x < count_x;

    lskv_ram #(.AW(AW), .DW(lskv_pkg::KEY_W)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    lskv_ram #(.AW(AW), .DW(lskv_pkg::VAL_W)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lskv_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.opcode)
                        lskv_pkg::OP_PUT,
                        lskv_pkg::OP_GET,
                        lskv_pkg::OP_HAS,
                        lskv_pkg::OP_REMOVE:   state_next = lskv_pkg::S_SCAN;
                        lskv_pkg::OP_KEY_AT,
                        lskv_pkg::OP_VALUE_AT: state_next = lskv_pkg::S_POS;
                        default:               state_next = lskv_pkg::S_DONE;
                    endcase
                end
            end
            lskv_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    case (op_reg)
                        lskv_pkg::OP_GET:    state_next = lskv_pkg::S_VAL;
                        lskv_pkg::OP_REMOVE: state_next = lskv_pkg::S_RM_A;
                        default:             state_next = lskv_pkg::S_DONE;
                    endcase
                end
                else if (scan_end)
                begin
                    state_next = lskv_pkg::S_DONE;
                end
            end
            lskv_pkg::S_VAL:   state_next = lskv_pkg::S_DONE;
            lskv_pkg::S_RM_A:  state_next = lskv_pkg::S_RM_B;
            lskv_pkg::S_RM_B:  state_next = lskv_pkg::S_DONE;
            lskv_pkg::S_POS:   state_next = in_range ? lskv_pkg::S_POS_D : lskv_pkg::S_DONE;
            lskv_pkg::S_POS_D: state_next = lskv_pkg::S_DONE;
            lskv_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = lskv_pkg::S_IDLE;
                end
            end
            default:           state_next = lskv_pkg::S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        count_next      = count_reg;
        issue_next      = issue_reg;
        rdv_next        = rdv_reg;
        rdidx_next      = rdidx_reg;
        slot_next       = slot_reg;
        res_found_next  = res_found_reg;
        res_val_next    = res_val_reg;
        res_key_next    = res_key_reg;
        res_status_next = res_status_reg;
        key_we          = 1'b0;
        val_we          = 1'b0;
        key_waddr       = slot_reg;
        val_waddr       = slot_reg;
        key_wdata       = key_rdata;
        val_wdata       = val_rdata;
        key_raddr       = AW'(issue_reg);
        val_raddr       = slot_reg;

        case (state_reg)
            lskv_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    issue_next      = '0;
                    rdv_next        = 1'b0;
                    res_found_next  = 1'b0;
                    res_val_next    = '0;
                    res_key_next    = '0;
                    res_status_next = lskv_pkg::ST_OK;
                end
            end
            lskv_pkg::S_SCAN:
            begin
                // keep one key read in flight per cycle
                rdv_next   = issue_reg < count_reg;
                rdidx_next = AW'(issue_reg);
                if (issue_reg < count_reg)
                begin
                    issue_next = issue_reg + CW'(1);
                end

                if (hit)
                begin
                    rdv_next       = 1'b0;
                    slot_next      = rdidx_reg;
                    res_found_next = 1'b1;
                    val_raddr      = rdidx_reg;
                    case (op_reg)
                        lskv_pkg::OP_PUT:
                        begin
                            val_we    = 1'b1;
                            val_waddr = rdidx_reg;
                            val_wdata = val_reg;
                        end
                        lskv_pkg::OP_REMOVE:
                        begin
                            // fetch the last entry to fill the hole
                            key_raddr = last_slot;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (scan_end && (op_reg == lskv_pkg::OP_PUT))
                begin
                    if (count_reg < CW'(DEPTH))
                    begin
                        key_we     = 1'b1;
                        val_we     = 1'b1;
                        key_waddr  = AW'(count_reg);
                        val_waddr  = AW'(count_reg);
                        key_wdata  = key_reg;
                        val_wdata  = val_reg;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        res_status_next = lskv_pkg::ST_FULL;
                    end
                end
            end
            lskv_pkg::S_VAL:
            begin
                res_val_next = val_rdata;
            end
            lskv_pkg::S_RM_A:
            begin
                res_val_next = val_rdata;
                key_we       = 1'b1;
                key_waddr    = slot_reg;
                key_wdata    = key_rdata;
                val_raddr    = last_slot;
            end
            lskv_pkg::S_RM_B:
            begin
                val_we     = 1'b1;
                val_waddr  = slot_reg;
                val_wdata  = val_rdata;
                count_next = count_reg - CW'(1);
            end
            lskv_pkg::S_POS:
            begin
                key_raddr = AW'(pos_x);
                val_raddr = AW'(pos_x);
                if (!in_range)
                begin
                    res_status_next = lskv_pkg::ST_RANGE;
                end
            end
            lskv_pkg::S_POS_D:
            begin
                res_found_next = 1'b1;
                if (op_reg == lskv_pkg::OP_KEY_AT)
                begin
                    res_key_next = key_rdata;
                end
                else
                begin
                    res_val_next = val_rdata;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lskv_pkg::S_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            rdv_reg       <= rdv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg  <= req.opcode;
            key_reg <= req.key;
            val_reg <= req.value;
            pos_reg <= req.position;
        end
        rdidx_reg      <= rdidx_next;
        slot_reg       <= slot_next;
        res_found_reg  <= res_found_next;
        res_val_reg    <= res_val_next;
        res_key_reg    <= res_key_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_found_reg  <= res_found_reg;
            out_val_reg    <= res_val_reg;
            out_key_reg    <= res_key_reg;
            out_status_reg <= res_status_reg;
            out_count_reg  <= lskv_pkg::COUNT_OUT_W'(count_reg);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.found        = out_found_reg;
    assign rsp.result_value = out_val_reg;
    assign rsp.result_key   = out_key_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.entry_count  = out_count_reg;

endmodule

[src/lskv_checker.sv]
// port-level checks for the key/value table, bound to the top level
module lskv_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic                             found,
    input logic [lskv_pkg::VAL_W-1:0]       result_value,
    input logic [lskv_pkg::KEY_W-1:0]       result_key,
    input logic [lskv_pkg::STATUS_W-1:0]    status
);

    // a result held back stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // one request at a time: the request side closes after a request is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // a refused put on a full table reports nothing found and no data
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == lskv_pkg::ST_FULL) |->
            !found && (result_value == '0) && (result_key == '0))
        else $error("full status with data");

    // an out of range position reports nothing
    a_range_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == lskv_pkg::ST_RANGE) |->
            !found && (result_value == '0) && (result_key == '0))
        else $error("range status with data");

    // a key comes back only from a successful positional read
    a_key_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (result_key != '0) |-> found && (status == lskv_pkg::ST_OK))
        else $error("key returned without a hit");

endmodule

bind linear_scan_key_value_table_top lskv_checker u_lskv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .found        (rsp.found),
    .result_value (rsp.result_value),
    .result_key   (rsp.result_key),
    .status       (rsp.status)
);

[tb/tb_linear_scan_key_value_table_top.sv]
`timescale 1ns / 100ps
// self-checking testbench for the linear scan key/value table, random and directed requests
module tb_linear_scan_key_value_table_top;

    localparam int DEPTH        = 64;
    localparam int RANDOM_ITEMS = 1950;
    // the watchdog limit lies well above the longest request plus the longest drawn gaps
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = DEPTH + 16;

    // the two opcodes the table does not define
    localparam logic [lskv_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd6;
    localparam logic [lskv_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

    // one request as it is offered on the request channel; opcodes six and seven are legal stimulus
    typedef struct packed {
        logic [lskv_pkg::OP_W-1:0]  opcode;
        logic [lskv_pkg::KEY_W-1:0] key;
        logic [lskv_pkg::VAL_W-1:0] value;
        logic [lskv_pkg::POS_W-1:0] position;
    } table_req_t;

    // what the table must answer to one request
    typedef struct packed {
        logic                             found;
        logic [lskv_pkg::VAL_W-1:0]       result_value;
        logic [lskv_pkg::KEY_W-1:0]       result_key;
        lskv_pkg::status_t                status;
        logic [lskv_pkg::COUNT_OUT_W-1:0] entry_count;
    } table_answer_t;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } phase_t;

    logic clk;
    logic rst_n;

    lskv_req_if req_ch ();
    lskv_rsp_if rsp_ch ();

    linear_scan_key_value_table_top #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the table contents, updated once per accepted request
    logic [lskv_pkg::KEY_W-1:0] shadow_keys [DEPTH];
    logic [lskv_pkg::VAL_W-1:0] shadow_vals [DEPTH];
    int                         shadow_fill;

    table_req_t    pending_reqs [$];   // requests not yet offered to the table
    table_answer_t answers_due  [$];   // answers owed for accepted requests, oldest first
    logic [lskv_pkg::KEY_W-1:0] live_keys [$];   // keys the stimulus believes are stored

    int  total_reqs;
    int  reqs_taken;
    int  answers_seen;
    int  mismatches;
    int  idle_cycles;
    int  req_gap;
    int  rsp_gap;
    bit  req_taken;
    bit  rsp_taken;

    // what the run reached
    int  hit_count;
    int  full_count;
    int  range_count;
    int  peak_fill;

    // clock, 10 ns period
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor: applies one request to the shadow table and returns the
    // answer; the lookup compares all 32 key bits over filled slots only
    // ------------------------------------------------------------------
    function automatic table_answer_t table_apply(table_req_t r);
        table_answer_t ans;
        int            slot;
        int            i;
        ans = '{found: 1'b0, result_value: '0, result_key: '0,
                status: lskv_pkg::ST_OK, entry_count: '0};
        slot = -1;
        for (i = 0; i < shadow_fill; i++)
        begin
            if (slot < 0 && shadow_keys[i] == r.key)
                slot = i;
        end
        case (r.opcode)
            lskv_pkg::OP_PUT:
            begin
                if (slot >= 0)
                begin
                    // key already present: only the value changes
                    shadow_vals[slot] = r.value;
                    ans.found = 1'b1;
                end
                else if (shadow_fill < DEPTH)
                begin
                    shadow_keys[shadow_fill] = r.key;
                    shadow_vals[shadow_fill] = r.value;
                    shadow_fill++;
                end
                else
                    ans.status = lskv_pkg::ST_FULL;
            end
            lskv_pkg::OP_GET:
            begin
                if (slot >= 0)
                begin
                    ans.found        = 1'b1;
                    ans.result_value = shadow_vals[slot];
                end
            end
            lskv_pkg::OP_HAS:
                ans.found = (slot >= 0);
            lskv_pkg::OP_REMOVE:
            begin
                if (slot >= 0)
                begin
                    // last entry moves into the freed slot
                    ans.found        = 1'b1;
                    ans.result_value = shadow_vals[slot];
                    shadow_fill--;
                    shadow_keys[slot] = shadow_keys[shadow_fill];
                    shadow_vals[slot] = shadow_vals[shadow_fill];
                end
            end
            lskv_pkg::OP_KEY_AT, lskv_pkg::OP_VALUE_AT:
            begin
                if (r.position < shadow_fill)
                begin
                    ans.found = 1'b1;
                    if (r.opcode == lskv_pkg::OP_KEY_AT)
                        ans.result_key = shadow_keys[r.position];
                    else
                        ans.result_value = shadow_vals[r.position];
                end
                else
                    ans.status = lskv_pkg::ST_RANGE;
            end
            default:
            begin
                // unused opcodes leave the table alone
            end
        endcase
        ans.entry_count = shadow_fill[lskv_pkg::COUNT_OUT_W-1:0];
        return ans;
    endfunction

    function automatic void queue_req(logic [lskv_pkg::OP_W-1:0] op,
                                      logic [lskv_pkg::KEY_W-1:0] k,
                                      logic [lskv_pkg::VAL_W-1:0] v,
                                      logic [lskv_pkg::POS_W-1:0] p);
        table_req_t r;
        r = '{opcode: op, key: k, value: v, position: p};
        pending_reqs.push_back(r);
    endfunction

    // idle cycles before the next transfer; calm stretches have none at all
    function automatic int draw_wait(bit calm);
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, want_v, got_v);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: samples both channels at the rising edge, predicts on each
    // accepted request and checks each accepted result; also the watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        table_req_t    seen_req;
        table_answer_t due;
        table_answer_t got;
        if (rst_n)
        begin
            req_taken <= req_ch.valid && req_ch.ready;
            rsp_taken <= rsp_ch.valid && rsp_ch.ready;

            if (req_ch.valid && req_ch.ready)
            begin
                seen_req = '{opcode: req_ch.opcode, key: req_ch.key,
                             value: req_ch.value, position: req_ch.position};
                due = table_apply(seen_req);
                answers_due.push_back(due);
                reqs_taken++;
                if (due.found)
                    hit_count++;
                if (due.status == lskv_pkg::ST_FULL)
                    full_count++;
                if (due.status == lskv_pkg::ST_RANGE)
                    range_count++;
                if (shadow_fill > peak_fill)
                    peak_fill = shadow_fill;
            end

            if (rsp_ch.valid && rsp_ch.ready)
            begin
                answers_seen++;
                if (answers_due.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual found %0b count %0d",
                             $time, rsp_ch.found, rsp_ch.entry_count);
                    mismatches++;
                end
                else
                begin
                    due = answers_due.pop_front();
                    got = '{found: rsp_ch.found, result_value: rsp_ch.result_value,
                            result_key: rsp_ch.result_key,
                            status: lskv_pkg::status_t'(rsp_ch.status),
                            entry_count: rsp_ch.entry_count};
                    check_field("found", due.found, rsp_ch.found);
                    check_field("result_value", due.result_value, got.result_value);
                    check_field("result_key", due.result_key, got.result_key);
                    check_field("status", due.status, rsp_ch.status);
                    check_field("entry_count", due.entry_count, rsp_ch.entry_count);
                end
            end

            // watchdog: cycles in which neither channel moves anything
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no transfer for %0d cycles, %0d answers outstanding",
                         $time, idle_cycles, answers_due.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // driver: changes inputs at the falling edge; holds a request until it
    // is taken, then waits its drawn gap; the result side stalls likewise
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        table_req_t nxt;
        if (rst_n)
        begin
            if (req_ch.valid && !req_taken)
            begin
                // request still waiting for the table
            end
            else if (req_gap > 0)
            begin
                req_ch.valid <= 1'b0;
                req_gap--;
            end
            else if (pending_reqs.size() != 0)
            begin
                nxt = pending_reqs.pop_front();
                req_ch.opcode   <= nxt.opcode;
                req_ch.key      <= nxt.key;
                req_ch.value    <= nxt.value;
                req_ch.position <= nxt.position;
                req_ch.valid    <= 1'b1;
                req_gap = draw_wait(((total_reqs - pending_reqs.size()) / 150) % 4 == 3);
            end
            else
                req_ch.valid <= 1'b0;

            // a fresh stall is drawn after every result taken
            if (rsp_taken)
                rsp_gap = draw_wait((answers_seen / 150) % 4 == 1);
            if (rsp_gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_gap--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        phase_t                     phase;
        int                         burst;
        int                         pick;
        int                         idx;
        bit                         have;
        bit                         from_live;
        logic [lskv_pkg::OP_W-1:0]  op;
        logic [lskv_pkg::KEY_W-1:0] k;
        logic [lskv_pkg::VAL_W-1:0] v;
        logic [lskv_pkg::POS_W-1:0] p;

        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.opcode   = '0;
        req_ch.key      = '0;
        req_ch.value    = '0;
        req_ch.position = '0;
        rsp_ch.ready    = 1'b0;
        req_taken       = 1'b0;
        rsp_taken       = 1'b0;
        shadow_fill     = 0;
        reqs_taken      = 0;
        answers_seen    = 0;
        mismatches      = 0;
        idle_cycles     = 0;
        req_gap         = 0;
        rsp_gap         = 0;
        hit_count       = 0;
        full_count      = 0;
        range_count     = 0;
        peak_fill       = 0;

        // empty table: misses, out-of-range positions and the unused opcodes
        queue_req(lskv_pkg::OP_GET,      32'h0000_0000, 32'h0,          6'd0);
        queue_req(lskv_pkg::OP_HAS,      32'hFFFF_FFFF, 32'h0,          6'd0);
        queue_req(lskv_pkg::OP_REMOVE,   32'h0000_0000, 32'h0,          6'd0);
        queue_req(lskv_pkg::OP_KEY_AT,   32'h0,         32'h0,          6'd0);
        queue_req(lskv_pkg::OP_VALUE_AT, 32'h0,         32'h0,          6'd63);
        queue_req(OP_UNUSED_LO,          32'hFFFF_FFFF, 32'hFFFF_FFFF,  6'd63);
        queue_req(OP_UNUSED_HI,          32'h5555_5555, 32'hAAAA_AAAA,  6'd21);
        // appends at the key and value extremes, an update of a present key, then another append
        queue_req(lskv_pkg::OP_PUT,      32'h0000_0000, 32'h0000_0000,  6'd0);
        queue_req(lskv_pkg::OP_PUT,      32'hFFFF_FFFF, 32'hFFFF_FFFF,  6'd63);
        queue_req(lskv_pkg::OP_PUT,      32'hFFFF_FFFF, 32'h1234_5678,  6'd0);
        queue_req(lskv_pkg::OP_PUT,      32'h8000_0000, 32'h0000_0001,  6'd0);
        // hits, a near-miss one bit away, and positional reads at the fill boundary
        queue_req(lskv_pkg::OP_GET,      32'hFFFF_FFFF, 32'h0,          6'd0);
        queue_req(lskv_pkg::OP_HAS,      32'h0000_0000, 32'h0,          6'd0);
        queue_req(lskv_pkg::OP_HAS,      32'hFFFF_FFFE, 32'h0,          6'd0);
        queue_req(lskv_pkg::OP_KEY_AT,   32'h0,         32'h0,          6'd1);
        queue_req(lskv_pkg::OP_VALUE_AT, 32'h0,         32'h0,          6'd2);
        queue_req(lskv_pkg::OP_KEY_AT,   32'h0,         32'h0,          6'd3);
        queue_req(lskv_pkg::OP_VALUE_AT, 32'h0,         32'h0,          6'd63);
        // remove of the first slot pulls the last entry in, then empty the table
        queue_req(lskv_pkg::OP_REMOVE,   32'h0000_0000, 32'h0,          6'd0);
        queue_req(lskv_pkg::OP_KEY_AT,   32'h0,         32'h0,          6'd0);
        queue_req(lskv_pkg::OP_REMOVE,   32'h8000_0000, 32'h0,          6'd0);
        queue_req(lskv_pkg::OP_REMOVE,   32'hFFFF_FFFF, 32'h0,          6'd0);
        queue_req(lskv_pkg::OP_GET,      32'hFFFF_FFFF, 32'h0,          6'd0);
        queue_req(lskv_pkg::OP_VALUE_AT, 32'h0,         32'h0,          6'd0);

        // random part in bursts: filling towards full, draining by remove,
        // and a free mix; keys mostly come from those believed stored
        while (pending_reqs.size() < RANDOM_ITEMS + 24)
        begin
            phase = phase_t'($urandom_range(0, 2));
            burst = $urandom_range(10, 80);
            repeat (burst)
            begin
                pick      = $urandom_range(0, 99);
                have      = (live_keys.size() != 0);
                idx       = have ? $urandom_range(0, live_keys.size() - 1) : 0;
                from_live = 1'b0;
                k         = $urandom;
                v         = $urandom;
                p         = lskv_pkg::POS_W'($urandom_range(0, 63));
                op        = lskv_pkg::OP_PUT;
                case (phase)
                    PH_FILL:
                    begin
                        if (pick < 70)
                            op = lskv_pkg::OP_PUT;
                        else if (pick < 80 && have)
                        begin
                            op        = lskv_pkg::OP_PUT;
                            k         = live_keys[idx];
                            from_live = 1'b1;
                        end
                        else
                        begin
                            op = (pick % 2) ? lskv_pkg::OP_GET : lskv_pkg::OP_HAS;
                            if (have && pick < 95)
                            begin
                                k         = live_keys[idx];
                                from_live = 1'b1;
                            end
                        end
                    end
                    PH_DRAIN:
                    begin
                        if (pick < 80 && have)
                        begin
                            op        = lskv_pkg::OP_REMOVE;
                            k         = live_keys[idx];
                            from_live = 1'b1;
                        end
                        else if (pick < 90)
                            op = lskv_pkg::OP_REMOVE;
                        else
                        begin
                            op = (pick % 2) ? lskv_pkg::OP_KEY_AT : lskv_pkg::OP_VALUE_AT;
                            p  = (live_keys.size() > 63) ? 6'd63 :
                                 lskv_pkg::POS_W'($urandom_range(0, live_keys.size()));
                        end
                    end
                    default:
                    begin
                        op = lskv_pkg::OP_W'($urandom_range(0, 7));
                        if (have && pick < 50)
                        begin
                            k         = live_keys[idx];
                            from_live = 1'b1;
                        end
                        else if (have && pick < 65)
                            k = live_keys[idx] ^ (32'h1 << $urandom_range(0, 31));
                        if (pick % 3 != 0)
                            p = (live_keys.size() > 63) ? 6'd63 :
                                lskv_pkg::POS_W'($urandom_range(0, live_keys.size()));
                    end
                endcase
                // keep the belief about stored keys in step
                if (op == lskv_pkg::OP_PUT && !from_live && live_keys.size() < DEPTH)
                    live_keys.push_back(k);
                if (op == lskv_pkg::OP_REMOVE && from_live)
                    live_keys.delete(idx);
                queue_req(op, k, v, p);
            end
        end
        total_reqs = pending_reqs.size();

        // reset is asserted from the start and released at a falling edge
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (reqs_taken < total_reqs)
            @(posedge clk);
        while (answers_due.size() != 0)
            @(posedge clk);
        // anything arriving late would show up as an unexpected result here
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d requests and checked %0d results: %0d hits, %0d refused puts",
                 reqs_taken, answers_seen, hit_count, full_count);
        $display("%0d positional reads out of range, peak fill %0d of %0d",
                 range_count, peak_fill, DEPTH);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
